>>> rtl/core/double_ended_queue_indexed_defines.svh
// Assertion macros for the indexed double-ended queue checker.
// Depends on nothing; the including module must have clk_i and rst_ni.
`ifndef DOUBLE_ENDED_QUEUE_INDEXED_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_INDEXED_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while reset is asserted.
`define DEQI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while reset is asserted.
`define DEQI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/deqi_pkg.sv
// Shared constants for the indexed double-ended queue.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package deqi_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ_POS   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_FRONT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_BACK  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

endpackage

`default_nettype wire

>>> rtl/core/double_ended_queue_indexed.sv
// Bounded double-ended queue with indexed reads: circular word store, pointer logic, output stage.
// Depends on deqi_pkg.
//
// Takes one request per clock cycle while in_stall_o is low; an accepted request passes through the
// s1 registers and then the output register. Each request makes at most one access to a single-port
// synchronous registered-read store of DEPTH words; the front pointer and the word count are updated
// in the cycle the request is accepted, so a read right after a push sees the pushed word.
// An output register decouples the result side: a new request is taken while a finished
// result still waits. The store is not cleared at reset or by a clear request; only words
// inside the occupied span are ever read.
`default_nettype none

module double_ended_queue_indexed
  import deqi_pkg::*;
#(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned PTR_W     = $clog2(DEPTH),
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [KIND_W-1:0]     kind_i,
  input  wire logic [DATA_WIDTH-1:0] value_i,
  input  wire logic [POS_W-1:0]      position_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0]      read_word_o,
  output logic [CNT_W-1:0]           count_o,
  output logic                       is_empty_o,
  output logic [STATUS_W-1:0]        status_o
);

  localparam int unsigned SUM_W = PTR_W + 1;
  localparam int unsigned CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  logic [PTR_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] occ_q, occ_d;

  logic                s1_valid_q;
  logic                s1_rd_q;
  logic [CNT_W-1:0]    s1_count_q;
  logic                s1_empty_q;
  logic [STATUS_W-1:0] s1_status_q;

  logic                  s2_valid_q;
  logic [DATA_WIDTH-1:0] s2_word_q;
  logic [CNT_W-1:0]      s2_count_q;
  logic                  s2_empty_q;
  logic [STATUS_W-1:0]   s2_status_q;

  logic                accept;
  logic                s2_load;
  logic                full;
  logic                empty_now;
  logic                pos_ok;
  logic [SUM_W-1:0]    offset;
  logic [SUM_W-1:0]    slot_sum;
  logic [PTR_W-1:0]    slot;
  logic [PTR_W-1:0]    front_dec;
  logic [PTR_W-1:0]    addr;
  logic                rd_en;
  logic                wr_en;
  logic [STATUS_W-1:0] status_d;

  assign s2_load    = s1_valid_q & (~s2_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s2_load;
  assign accept     = in_valid_i & ~in_stall_o;

  assign full      = (occ_q == DEPTH_CNT);
  assign empty_now = (occ_q == '0);
  assign pos_ok    = CMP_W'(position_i) < CMP_W'(occ_q);
  assign front_dec = (front_q == '0) ? LAST_PTR : PTR_W'(front_q - 1'b1);

  always_comb begin
    case (kind_i)
      KIND_PUSH_BACK: offset = SUM_W'(occ_q);
      KIND_READ_POS:  offset = SUM_W'(position_i);
      KIND_READ_BACK: offset = SUM_W'(CNT_W'(occ_q - 1'b1));
      default:        offset = '0;
    endcase
  end

  assign slot_sum = SUM_W'(front_q) + offset;
  assign slot     = (slot_sum >= DEPTH_SUM) ? PTR_W'(slot_sum - DEPTH_SUM) : PTR_W'(slot_sum);

  always_comb begin
    front_d  = front_q;
    occ_d    = occ_q;
    status_d = STATUS_OK;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    addr     = slot;
    case (kind_i)
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          front_d = front_dec;
          occ_d   = CNT_W'(occ_q + 1'b1);
          wr_en   = 1'b1;
          addr    = front_dec;
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          occ_d = CNT_W'(occ_q + 1'b1);
          wr_en = 1'b1;
        end
      end
      KIND_READ_POS: begin
        if (!pos_ok) begin
          status_d = STATUS_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      KIND_READ_FRONT, KIND_READ_BACK: begin
        if (empty_now) begin
          status_d = STATUS_EMPTY;
        end else begin
          rd_en = 1'b1;
        end
      end
      KIND_CLEAR: begin
        front_d = '0;
        occ_d   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      mem[addr] <= value_i;
    end
    if (accept && rd_en) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q    <= '0;
      occ_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        front_q <= front_d;
        occ_q   <= occ_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_q     <= rd_en;
      s1_count_q  <= occ_d;
      s1_empty_q  <= (occ_d == '0);
      s1_status_q <= status_d;
    end
    if (s2_load) begin
      s2_word_q   <= s1_rd_q ? rdata_q : '0;
      s2_count_q  <= s1_count_q;
      s2_empty_q  <= s1_empty_q;
      s2_status_q <= s1_status_q;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign read_word_o = s2_word_q;
  assign count_o     = s2_count_q;
  assign is_empty_o  = s2_empty_q;
  assign status_o    = s2_status_q;

endmodule

`default_nettype wire

>>> rtl/core/deqi_checker.sv
// Port-level checks on the result channel of the indexed double-ended queue, plus its bind.
// Depends on deqi_pkg and double_ended_queue_indexed_defines.svh.
`default_nettype none

`include "double_ended_queue_indexed_defines.svh"

module deqi_checker
  import deqi_pkg::*;
#(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [DATA_WIDTH-1:0] read_word_o,
  input wire logic [CNT_W-1:0]      count_o,
  input wire logic                  is_empty_o,
  input wire logic [STATUS_W-1:0]   status_o
);

  `DEQI_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(read_word_o) && $stable(count_o) && $stable(status_o),
    "stalled result beat changed")

  `DEQI_ASSERT_IMPL(a_empty_flag, out_valid_o, is_empty_o == (count_o == '0),
    "empty flag disagrees with count")

  `DEQI_ASSERT_IMPL(a_error_word, out_valid_o && (status_o != STATUS_OK), read_word_o == '0,
    "failed request returned a nonzero word")

  `DEQI_ASSERT_IMPL(a_count_bound, out_valid_o, count_o <= CNT_W'(DEPTH),
    "count exceeds depth")

endmodule

bind double_ended_queue_indexed deqi_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_deqi_checker (.*);

`default_nettype wire

>>> dv/double_ended_queue_indexed_tb.sv
// Self-checking testbench for the indexed double-ended queue: directed corner requests,
// then random fill, mixed and full-queue traffic with random idling on both channels.
// Depends on deqi_pkg and double_ended_queue_indexed; predicts every result in-line.
`timescale 1ns / 1ps

module double_ended_queue_indexed_tb;
  import deqi_pkg::*;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned RANDOM_REQS = 1950;

  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [DATA_WIDTH-1:0] value;
    logic [POS_W-1:0]      position;
  } request_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] word;
    logic [CNT_W-1:0]      count;
    logic                  empty;
    logic [STATUS_W-1:0]   status;
  } answer_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [KIND_W-1:0]     kind_i;
  logic [DATA_WIDTH-1:0] value_i;
  logic [POS_W-1:0]      position_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [DATA_WIDTH-1:0] read_word_o;
  logic [CNT_W-1:0]      count_o;
  logic                  is_empty_o;
  logic [STATUS_W-1:0]   status_o;

  double_ended_queue_indexed #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_word_o (read_word_o),
    .count_o     (count_o),
    .is_empty_o  (is_empty_o),
    .status_o    (status_o)
  );

  request_t    pending_reqs[$];
  answer_t     answers_due[$];
  request_t    next_req;
  answer_t     got;
  answer_t     want;

  logic [DATA_WIDTH-1:0] shadow_mem [DEPTH];
  logic [POS_W-1:0]      shadow_head;
  logic [CNT_W-1:0]      shadow_count;

  int unsigned gen_count;
  int unsigned gen_total;
  int unsigned tx_gap, tx_calm, rx_wait, rx_calm;
  int unsigned accepted_reqs, checked_answers, error_count;
  int unsigned full_pushes, range_misses, empty_reads, peak_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned hold_len(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      calm = $urandom_range(40, 200);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 170) return $urandom_range(1, 3);
    if (r < 194) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic answer_t compute_answer(logic [KIND_W-1:0] kind,
                                             logic [DATA_WIDTH-1:0] value,
                                             logic [POS_W-1:0] position);
    answer_t a;
    a = '0;
    a.status = STATUS_OK;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (shadow_count == CNT_W'(DEPTH)) begin
          a.status = STATUS_FULL;
          full_pushes++;
        end else if (kind == KIND_PUSH_FRONT) begin
          shadow_head = shadow_head - 1'b1;
          shadow_mem[shadow_head] = value;
          shadow_count++;
        end else begin
          shadow_mem[POS_W'(shadow_head + shadow_count[POS_W-1:0])] = value;
          shadow_count++;
        end
      end
      KIND_READ_POS: begin
        if (CNT_W'(position) >= shadow_count) begin
          a.status = STATUS_RANGE;
          range_misses++;
        end else begin
          a.word = shadow_mem[POS_W'(shadow_head + position)];
        end
      end
      KIND_READ_FRONT, KIND_READ_BACK: begin
        if (shadow_count == '0) begin
          a.status = STATUS_EMPTY;
          empty_reads++;
        end else if (kind == KIND_READ_FRONT) begin
          a.word = shadow_mem[shadow_head];
        end else begin
          a.word = shadow_mem[POS_W'(shadow_head + shadow_count[POS_W-1:0] - 1'b1)];
        end
      end
      KIND_CLEAR: begin
        shadow_head  = '0;
        shadow_count = '0;
      end
      default: begin
      end
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
    a.count = shadow_count;
    a.empty = (shadow_count == '0);
    return a;
  endfunction

  function automatic void queue_req(logic [KIND_W-1:0] kind, logic [DATA_WIDTH-1:0] value,
                                    logic [POS_W-1:0] position);
    request_t r;
    r.kind     = kind;
    r.value    = value;
    r.position = position;
    pending_reqs.insert(pending_reqs.size(), r);
    gen_total++;
    if ((kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) && gen_count < DEPTH) gen_count++;
    if (kind == KIND_CLEAR) gen_count = 0;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (gen_count > 0 && $urandom_range(0, 5) != 0) return POS_W'($urandom_range(0, gen_count - 1));
    return POS_W'($urandom_range(0, DEPTH - 1));
  endfunction

  function automatic void queue_mixed(int unsigned n, int unsigned push_pct);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < push_pct)
        queue_req($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, $urandom(), '0);
      else if (r < push_pct + (96 - push_pct) / 2)
        queue_req(KIND_READ_POS, $urandom(), pick_position());
      else if (r < 96)
        queue_req($urandom_range(0, 1) ? KIND_READ_BACK : KIND_READ_FRONT, $urandom(),
                  POS_W'($urandom()));
      else if (r < 98)
        queue_req(KIND_CLEAR, $urandom(), POS_W'($urandom()));
      else
        queue_req($urandom_range(0, 1) ? KIND_SPARE_7 : KIND_SPARE_6, $urandom(),
                  POS_W'($urandom()));
    end
  endfunction

  // request channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        answers_due.insert(answers_due.size(), compute_answer(kind_i, value_i, position_i));
        accepted_reqs++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          kind_i     <= next_req.kind;
          value_i    <= next_req.value;
          position_i <= next_req.position;
          in_valid_i <= 1'b1;
          tx_gap = hold_len(tx_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{word: read_word_o, count: count_o, empty: is_empty_o, status: status_o};
        if (answers_due.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: unexpected result word %h count %0d empty %0b status %0d",
                     got.word, got.count, got.empty, got.status);
        end else begin
          want = answers_due.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= 10)
              $display("ERROR: result %0d: expected word %h count %0d empty %0b status %0d,",
                       checked_answers, want.word, want.count, want.empty, want.status,
                       " got word %h count %0d empty %0b status %0d",
                       got.word, got.count, got.empty, got.status);
          end
        end
        checked_answers++;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        rx_wait = hold_len(rx_calm);
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_CLEAR;
    value_i     = '0;
    position_i  = '0;
    out_stall_i = 1'b0;
    shadow_head  = '0;
    shadow_count = '0;

    // directed corners: empty reads, spare kinds, word extremes, range edges, wrap
    queue_req(KIND_READ_FRONT, '0, '0);
    queue_req(KIND_READ_BACK, '1, '1);
    queue_req(KIND_READ_POS, '0, '0);
    queue_req(KIND_SPARE_6, '1, '1);
    queue_req(KIND_SPARE_7, '0, '0);
    queue_req(KIND_CLEAR, '0, '0);
    queue_req(KIND_PUSH_BACK, 32'hFFFF_FFFF, '0);
    queue_req(KIND_PUSH_FRONT, 32'h0000_0000, '1);
    queue_req(KIND_PUSH_BACK, 32'hA5A5_A5A5, '0);
    queue_req(KIND_PUSH_FRONT, 32'h5A5A_5A5A, '0);
    for (int i = 0; i < 5; i++) queue_req(KIND_READ_POS, '0, POS_W'(i));
    queue_req(KIND_READ_POS, '0, '1);
    queue_req(KIND_READ_FRONT, '0, '0);
    queue_req(KIND_READ_BACK, '0, '0);
    queue_req(KIND_CLEAR, '1, '1);
    queue_req(KIND_READ_FRONT, '0, '0);
    queue_req(KIND_PUSH_FRONT, 32'h8000_0001, '0);
    queue_req(KIND_READ_BACK, '0, '0);
    queue_req(KIND_READ_POS, '0, '0);
    gen_total = 0;

    queue_mixed(350, 50);
    while (gen_count < DEPTH) begin
      if ($urandom_range(0, 4) != 0)
        queue_req($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, $urandom(), '0);
      else
        queue_req(KIND_READ_POS, $urandom(), pick_position());
    end
    repeat (80) begin
      case ($urandom_range(0, 3))
        0: queue_req($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, $urandom(), '0);
        1: queue_req($urandom_range(0, 1) ? KIND_READ_BACK : KIND_READ_FRONT, '0, '0);
        default: queue_req(KIND_READ_POS, '0, POS_W'($urandom_range(0, DEPTH - 1)));
      endcase
    end
    if (gen_total < RANDOM_REQS) queue_mixed(RANDOM_REQS - gen_total, 45);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || in_valid_i) @(posedge clk_i);
    while (answers_due.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Accepted %0d requests and checked %0d results; peak occupancy %0d of %0d.",
             accepted_reqs, checked_answers, peak_count, DEPTH);
    $display("Refused pushes %0d, out-of-range reads %0d, empty front/back reads %0d.",
             full_pushes, range_misses, empty_reads);
    if (error_count == 0 && answers_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/deqi_pkg.sv
rtl/core/double_ended_queue_indexed.sv
rtl/core/deqi_checker.sv
dv/double_ended_queue_indexed_tb.sv
